@@ hw/rtl/online_baseline_threshold_top_defines.svh @@
// ----------------------------------------------------------------------------
// Online baseline threshold: assertion macros
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ONLINE_BASELINE_THRESHOLD_TOP_DEFINES_SVH
`define ONLINE_BASELINE_THRESHOLD_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define OBT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define OBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/obt_pkg.sv @@
// ----------------------------------------------------------------------------
// Online baseline threshold package
// Types and fixed constants shared by the iterative unit and the top level.
// ----------------------------------------------------------------------------
package obt_pkg;

  // Width of the shared arithmetic datapath.
  localparam int CALC_BITS  = 64;
  localparam int STEP_BITS  = $clog2(CALC_BITS + 1);
  localparam int COUNT_BITS = 32;
  localparam int THR_BITS   = 16;
  localparam int SIGMA_BITS = 12;
  localparam int SIGMA_FRAC = 8;
  localparam int SQRT_STEPS = CALC_BITS / 2;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_THRESHOLD  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIGMA_MULT     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_SAMPLES    = 3'd4;

  localparam logic [THR_BITS-1:0]   BASE_THRESHOLD_RST = 16'd2;
  localparam logic [THR_BITS-1:0]   MIN_THRESHOLD_RST  = 16'd1;
  localparam logic [THR_BITS-1:0]   MAX_THRESHOLD_RST  = 16'd100;
  localparam logic [SIGMA_BITS-1:0] SIGMA_MULT_RST     = 12'd768;
  localparam logic [THR_BITS-1:0]   MIN_SAMPLES_RST    = 16'd10;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic                 start;
    unit_op_t             op;
    logic [CALC_BITS-1:0] a;
    logic [CALC_BITS-1:0] b;
    logic [STEP_BITS-1:0] steps;
  } unit_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [CALC_BITS-1:0] result;
  } unit_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV_MEAN,
    S_MUL_DEV,
    S_MUL_WAIT,
    S_DIV_VAR,
    S_CHECK,
    S_SQRT,
    S_MUL_SIG,
    S_ROUND,
    S_OUT
  } state_t;

endpackage

@@ hw/rtl/obt_ifs.sv @@
// ----------------------------------------------------------------------------
// Online baseline threshold channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface obt_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface obt_result_if;
  logic                          valid;
  logic                          ready;
  logic [obt_pkg::THR_BITS-1:0]  threshold;
  logic                          baseline_ready;

  modport source (output valid, output threshold, output baseline_ready, input ready);
  modport sink (input valid, input threshold, input baseline_ready, output ready);
endinterface

interface obt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [obt_pkg::CFG_INDEX_BITS-1:0] index;
  logic [obt_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/online_baseline_threshold_top.sv @@
// ----------------------------------------------------------------------------
// Online baseline threshold
// A zero sample skips the mean and variance update, and before the baseline is
// ready the square root and sigma multiply are skipped.
// One sample at a time; the next is taken once the result is in the output register.
// Reset clears count, mean and variance and loads the register defaults.
// ----------------------------------------------------------------------------
`include "online_baseline_threshold_top_defines.svh"

module online_baseline_threshold_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  obt_sample_if.sink    sample_ch,
  obt_result_if.source  result_ch,
  obt_cfg_if.sink       cfg_ch
);

  localparam int CW    = obt_pkg::CALC_BITS;
  localparam int CNT_W = obt_pkg::COUNT_BITS;
  localparam int TW    = obt_pkg::THR_BITS;
  localparam int SGW   = obt_pkg::SIGMA_BITS;
  localparam int SW    = obt_pkg::STEP_BITS;
  localparam int MW    = SAMPLE_BITS + FRAC_BITS;
  localparam int VW    = 2 * SAMPLE_BITS + FRAC_BITS;
  localparam int PAD   = CW - MW;
  localparam int FBS   = FRAC_BITS + obt_pkg::SIGMA_FRAC;

  // Registers
  logic [TW-1:0]  base_threshold;
  logic [TW-1:0]  min_threshold;
  logic [TW-1:0]  max_threshold;
  logic [SGW-1:0] sigma_mult;
  logic [TW-1:0]  min_samples;

  // Statistics state
  logic [CNT_W-1:0] sample_count;
  logic [MW-1:0]    running_mean;
  logic [VW-1:0]    running_var;

  // Per-request working registers
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [MW-1:0]          dev;
  logic                   up;
  logic                   var_up;
  logic [CW-1:0]          sum_q;
  logic                   ready_q;
  logic [TW-1:0]          thr_q;

  logic          out_valid;
  logic [TW-1:0] out_threshold;
  logic          out_ready_flag;

  obt_pkg::state_t     state;
  obt_pkg::state_t     state_next;
  obt_pkg::unit_req_t  unit_req;
  obt_pkg::unit_stat_t unit_stat;

  logic [MW-1:0] xf;
  logic          d_up;
  logic [MW-1:0] dev_calc;
  logic [MW-1:0] d2;
  logic [CW-1:0] var64;
  logic [CW-1:0] term;
  logic          var_grow;
  logic [CW-1:0] var_diff;
  logic [CW-1:0] var_shl;
  logic [CW-1:0] mean_shl;
  logic [CW:0]   sum_full;
  logic [CW-1:0] sum_sat;
  logic [CW-1:0] t_ceil;
  logic [TW-1:0] t_hi;
  logic [TW-1:0] t_clamped;
  logic          ready_calc;
  logic          accept;
  logic          out_load;

  obt_iter_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (unit_req),
    .stat (unit_stat)
  );

  assign accept = sample_ch.valid && sample_ch.ready;
  assign out_load = (state == obt_pkg::S_OUT) && (!out_valid || result_ch.ready);

  // Welford datapath; d and d2 always share the sign held in up.
  assign xf       = {sample_q, {FRAC_BITS{1'b0}}};
  assign d_up     = xf >= running_mean;
  assign dev_calc = d_up ? xf - running_mean : running_mean - xf;
  assign d2       = up ? xf - running_mean : running_mean - xf;
  assign var64    = CW'(running_var);
  assign term     = unit_stat.result >> FRAC_BITS;
  assign var_grow = term >= var64;
  assign var_diff = var_grow ? term - var64 : var64 - term;

  // Threshold datapath, saturating where the sums could overflow.
  assign var_shl  = ((var64 >> (CW - FRAC_BITS)) != '0) ? '1 : (var64 << FRAC_BITS);
  assign mean_shl = CW'(running_mean) << obt_pkg::SIGMA_FRAC;
  assign sum_full = {1'b0, mean_shl} + {1'b0, unit_stat.result};
  assign sum_sat  = sum_full[CW] ? '1 : sum_full[CW-1:0];
  assign t_ceil   = (sum_q >> FBS) + CW'(|sum_q[FBS-1:0]);
  assign t_hi     = (t_ceil > CW'(max_threshold)) ? max_threshold : t_ceil[TW-1:0];
  // Min above max: the lower clamp wins.
  assign t_clamped  = (t_hi < min_threshold) ? min_threshold : t_hi;
  assign ready_calc = sample_count >= CNT_W'(min_samples);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    unit_req.start  = 1'b0;
    unit_req.op     = obt_pkg::OP_MUL;
    unit_req.a      = '0;
    unit_req.b      = '0;
    unit_req.steps  = '0;
    sample_ch.ready = 1'b0;
    unique case (state)
      obt_pkg::S_IDLE: begin
        sample_ch.ready = 1'b1;
        if (sample_ch.valid) begin
          state_next = obt_pkg::S_UPDATE;
        end
      end
      obt_pkg::S_UPDATE: begin
        if (sample_q == '0 || sample_count == CNT_W'(1)) begin
          state_next = obt_pkg::S_CHECK;
        end else begin
          unit_req.start = 1'b1;
          unit_req.op    = obt_pkg::OP_DIV;
          unit_req.a     = {dev_calc, {PAD{1'b0}}};
          unit_req.b     = CW'(sample_count);
          unit_req.steps = SW'(MW);
          state_next     = obt_pkg::S_DIV_MEAN;
        end
      end
      obt_pkg::S_DIV_MEAN: begin
        if (unit_stat.done) begin
          state_next = obt_pkg::S_MUL_DEV;
        end
      end
      obt_pkg::S_MUL_DEV: begin
        unit_req.start = 1'b1;
        unit_req.op    = obt_pkg::OP_MUL;
        unit_req.a     = {d2, {PAD{1'b0}}};
        unit_req.b     = CW'(dev);
        unit_req.steps = SW'(MW);
        state_next     = obt_pkg::S_MUL_WAIT;
      end
      obt_pkg::S_MUL_WAIT: begin
        if (unit_stat.done) begin
          unit_req.start = 1'b1;
          unit_req.op    = obt_pkg::OP_DIV;
          unit_req.a     = var_diff;
          unit_req.b     = CW'(sample_count);
          unit_req.steps = SW'(CW);
          state_next     = obt_pkg::S_DIV_VAR;
        end
      end
      obt_pkg::S_DIV_VAR: begin
        if (unit_stat.done) begin
          state_next = obt_pkg::S_CHECK;
        end
      end
      obt_pkg::S_CHECK: begin
        if (ready_calc) begin
          unit_req.start = 1'b1;
          unit_req.op    = obt_pkg::OP_SQRT;
          unit_req.a     = var_shl;
          unit_req.steps = SW'(obt_pkg::SQRT_STEPS);
          state_next     = obt_pkg::S_SQRT;
        end else begin
          state_next = obt_pkg::S_OUT;
        end
      end
      obt_pkg::S_SQRT: begin
        if (unit_stat.done) begin
          unit_req.start = 1'b1;
          unit_req.op    = obt_pkg::OP_MUL;
          unit_req.a     = {sigma_mult, {(CW - SGW){1'b0}}};
          unit_req.b     = unit_stat.result;
          unit_req.steps = SW'(SGW);
          state_next     = obt_pkg::S_MUL_SIG;
        end
      end
      obt_pkg::S_MUL_SIG: begin
        if (unit_stat.done) begin
          state_next = obt_pkg::S_ROUND;
        end
      end
      obt_pkg::S_ROUND: begin
        state_next = obt_pkg::S_OUT;
      end
      obt_pkg::S_OUT: begin
        if (!out_valid || result_ch.ready) begin
          state_next = obt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = obt_pkg::S_IDLE;
      end
    endcase
  end

  // Register writes; indexes beyond the list are ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_threshold <= obt_pkg::BASE_THRESHOLD_RST;
      min_threshold  <= obt_pkg::MIN_THRESHOLD_RST;
      max_threshold  <= obt_pkg::MAX_THRESHOLD_RST;
      sigma_mult     <= obt_pkg::SIGMA_MULT_RST;
      min_samples    <= obt_pkg::MIN_SAMPLES_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        obt_pkg::CFG_BASE_THRESHOLD: base_threshold <= cfg_ch.data;
        obt_pkg::CFG_MIN_THRESHOLD:  min_threshold  <= cfg_ch.data;
        obt_pkg::CFG_MAX_THRESHOLD:  max_threshold  <= cfg_ch.data;
        obt_pkg::CFG_SIGMA_MULT:     sigma_mult     <= cfg_ch.data[SGW-1:0];
        obt_pkg::CFG_MIN_SAMPLES:    min_samples    <= cfg_ch.data;
        default: begin
          base_threshold <= base_threshold;
        end
      endcase
    end
  end

  // Statistics state. The count saturates, so the first-sample case is
  // never taken again once it has reached all ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      running_mean <= '0;
      running_var  <= '0;
    end else begin
      if (accept && sample_count != '1) begin
        sample_count <= sample_count + 1'b1;
      end
      if (state == obt_pkg::S_UPDATE && sample_q != '0 && sample_count == CNT_W'(1)) begin
        running_mean <= xf;
        running_var  <= '0;
      end
      if (state == obt_pkg::S_DIV_MEAN && unit_stat.done) begin
        running_mean <= up ? running_mean + MW'(unit_stat.result)
                           : running_mean - MW'(unit_stat.result);
      end
      if (state == obt_pkg::S_DIV_VAR && unit_stat.done) begin
        running_var <= var_up ? VW'(var64 + unit_stat.result)
                              : VW'(var64 - unit_stat.result);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample_ch.sample;
    end
    if (state == obt_pkg::S_UPDATE) begin
      dev <= dev_calc;
      up  <= d_up;
    end
    if (state == obt_pkg::S_MUL_WAIT && unit_stat.done) begin
      var_up <= var_grow;
    end
    if (state == obt_pkg::S_CHECK) begin
      ready_q <= ready_calc;
      thr_q   <= base_threshold;
    end
    if (state == obt_pkg::S_MUL_SIG && unit_stat.done) begin
      sum_q <= sum_sat;
    end
    if (state == obt_pkg::S_ROUND) begin
      thr_q <= t_clamped;
    end
  end

  // Output register: the finished request waits here while the next is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_threshold  <= thr_q;
      out_ready_flag <= ready_q;
    end
  end

  assign result_ch.valid          = out_valid;
  assign result_ch.threshold      = out_threshold;
  assign result_ch.baseline_ready = out_ready_flag;

  `OBT_ASSERT_IMPL(a_unit_start_free, unit_req.start, !unit_stat.busy, "unit started while busy")
  `OBT_ASSERT_IMPL(a_unit_done_busy, unit_stat.done, $past(unit_stat.busy), "done without work")
  `OBT_ASSERT_NEXT(a_count_step, accept && sample_count != '1, sample_count == $past(sample_count) + 32'd1, "sample count did not advance")

endmodule

@@ hw/rtl/obt_iter_unit.sv @@
// ----------------------------------------------------------------------------
// Online baseline threshold: iterative arithmetic unit
// One 65-bit add/subtract shared by a shift-add multiplier, a restoring
// divider and a digit-by-digit square root, one bit or digit per cycle.
// ----------------------------------------------------------------------------
module obt_iter_unit (
  input  logic                clk,
  input  logic                rst,
  input  obt_pkg::unit_req_t  req,
  output obt_pkg::unit_stat_t stat
);

  localparam int CW = obt_pkg::CALC_BITS;

  logic                          busy;
  logic                          done;
  obt_pkg::unit_op_t             op_r;
  logic [obt_pkg::STEP_BITS-1:0] cnt;
  logic [CW-1:0]                 acc;
  logic [CW-1:0]                 opa;
  logic [CW-1:0]                 opb;
  logic                          ovf;

  logic [CW:0] x;
  logic [CW:0] y;
  logic        sub;
  logic [CW:0] sum;
  logic        launch;

  assign launch = req.start && !busy;

  // Operand selection for the shared adder.
  always_comb begin
    x   = '0;
    y   = '0;
    sub = 1'b0;
    unique case (op_r)
      obt_pkg::OP_MUL: begin
        x = {1'b0, acc[CW-2:0], 1'b0};
        y = opa[CW-1] ? {1'b0, opb} : '0;
      end
      obt_pkg::OP_DIV: begin
        x   = {1'b0, acc[CW-2:0], opa[CW-1]};
        y   = {1'b0, opb};
        sub = 1'b1;
      end
      obt_pkg::OP_SQRT: begin
        x   = {1'b0, acc[CW-3:0], opa[CW-1:CW-2]};
        y   = {1'b0, opb[CW-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        x = '0;
      end
    endcase
    sum = sub ? x - y : x + y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (launch) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == obt_pkg::STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Working registers: a borrow in bit CW means the trial subtraction failed.
  always_ff @(posedge clk) begin
    if (launch) begin
      op_r <= req.op;
      acc  <= '0;
      opa  <= req.a;
      opb  <= req.b;
      ovf  <= 1'b0;
    end else if (busy) begin
      case (op_r)
        obt_pkg::OP_MUL: begin
          acc <= sum[CW-1:0];
          ovf <= ovf | acc[CW-1] | sum[CW];
          opa <= {opa[CW-2:0], 1'b0};
        end
        obt_pkg::OP_DIV: begin
          acc <= sum[CW] ? x[CW-1:0] : sum[CW-1:0];
          opa <= {opa[CW-2:0], !sum[CW]};
        end
        obt_pkg::OP_SQRT: begin
          acc <= sum[CW] ? x[CW-1:0] : sum[CW-1:0];
          opb <= {opb[CW-2:0], !sum[CW]};
          opa <= {opa[CW-3:0], 2'b00};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  always_comb begin
    stat.busy = busy;
    stat.done = done;
    unique case (op_r)
      obt_pkg::OP_MUL:  stat.result = ovf ? '1 : acc;
      obt_pkg::OP_DIV:  stat.result = opa;
      obt_pkg::OP_SQRT: stat.result = opb;
      default:          stat.result = acc;
    endcase
  end

endmodule
